// ----- hw/rtl/nes_pkg.sv -----
`timescale 1ns / 1ps
package nes_pkg;

   localparam int LEN_W = 9;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_PLAY = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   localparam logic [1:0] KIND_FREQ    = 2'd0;
   localparam logic [1:0] KIND_VOL     = 2'd1;
   localparam logic [1:0] KIND_SILENCE = 2'd2;
   localparam logic [1:0] KIND_STATUS  = 2'd3;

   localparam logic [1:0] SEL_NONE = 2'd0;
   localparam logic [1:0] SEL_OFF  = 2'd1;
   localparam logic [1:0] SEL_FREQ = 2'd2;
   localparam logic [1:0] SEL_VOL  = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  track;
      logic [7:0]  event_index;
      logic        last_of_track;
      logic [31:0] start_time;
      logic [31:0] duration;
      logic [31:0] phase_increment;
      logic [7:0]  volume;
      logic [7:0]  event_channel;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  osc_channel;
      logic [31:0] value;
      logic        playing;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] st;
      logic [31:0] du;
      logic [31:0] ph;
      logic [7:0]  vo;
      logic [7:0]  ec;
   } event_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  ch;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic       dec;
      logic       mem_wr;
      logic       play_init;
      logic       stop;
      logic       origin;
      logic       t_inc;
      logic       off_clr;
      logic       rd_issue;
      logic       note_on;
      logic       fin;
      logic       drain;
      logic       wr_en;
      logic [1:0] wr_kind;
      logic [1:0] wr_sel;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       run;
      logic       tc_nz;
      logic       no_trk;
      logic       off_hit;
      logic       can_read;
      logic       ev_due;
      logic       last_trk;
      logic       trk_fin;
      logic       buf_empty;
   } sts_type;

endpackage

// ----- hw/rtl/nes_ctrl.sv -----
`timescale 1ns / 1ps
module nes_ctrl
   import nes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_ORG   = 4'd2;
   localparam logic [3:0] S_OFF   = 4'd3;
   localparam logic [3:0] S_OFF2  = 4'd4;
   localparam logic [3:0] S_TEST  = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_VOL   = 4'd7;
   localparam logic [3:0] S_TDONE = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_STAT  = 4'd10;
   localparam logic [3:0] S_DRAIN = 4'd11;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.dec  = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_STAT;
            unique case (sts.cmd)
               CMD_LOAD: ctl.mem_wr = 1'b1;
               CMD_PLAY: begin
                  if (sts.tc_nz) begin
                     ctl.play_init = 1'b1;
                     ctl.wr_en     = 1'b1;
                     ctl.wr_kind   = KIND_SILENCE;
                  end
               end
               CMD_STOP: begin
                  ctl.stop    = 1'b1;
                  ctl.wr_en   = 1'b1;
                  ctl.wr_kind = KIND_SILENCE;
               end
               default: begin
                  if (sts.run) state_in = S_ORG;
               end
            endcase
         end
         S_ORG: begin
            ctl.origin = 1'b1;
            state_in   = sts.no_trk ? S_FIN : S_OFF;
         end
         S_OFF: begin
            if (sts.off_hit) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_kind = KIND_VOL;
               ctl.wr_sel  = SEL_OFF;
               state_in    = S_OFF2;
            end else begin
               state_in = S_TEST;
            end
         end
         S_OFF2: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_kind = KIND_FREQ;
            ctl.wr_sel  = SEL_OFF;
            ctl.off_clr = 1'b1;
            state_in    = S_TEST;
         end
         S_TEST: begin
            if (sts.can_read) begin
               ctl.rd_issue = 1'b1;
               state_in     = S_WAIT;
            end else begin
               state_in = S_TDONE;
            end
         end
         S_WAIT: begin
            if (sts.ev_due) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_kind = KIND_FREQ;
               ctl.wr_sel  = SEL_FREQ;
               state_in    = S_VOL;
            end else begin
               state_in = S_TDONE;
            end
         end
         S_VOL: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_kind = KIND_VOL;
            ctl.wr_sel  = SEL_VOL;
            ctl.note_on = 1'b1;
            state_in    = S_TEST;
         end
         S_TDONE: begin
            ctl.t_inc = 1'b1;
            state_in  = sts.last_trk ? S_FIN : S_OFF;
         end
         S_FIN: begin
            ctl.fin = 1'b1;
            if (sts.trk_fin) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_kind = KIND_SILENCE;
            end
            state_in = S_STAT;
         end
         S_STAT: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_kind = KIND_STATUS;
            state_in    = S_DRAIN;
         end
         S_DRAIN: begin
            ctl.drain = 1'b1;
            if (sts.buf_empty) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> sts.buf_empty) else $error("results left in buffer");
   a_stat_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STAT |=> state_ff == S_DRAIN) else $error("status not followed by drain");
   a_idle_nowr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ctl.wr_en) else $error("buffer write while idle");

endmodule

// ----- hw/rtl/nes_datapath.sv -----
`timescale 1ns / 1ps
module nes_datapath
   import nes_pkg::*;
#(
   parameter int TRACKS           = 4,
   parameter int CHANNELS         = 4,
   parameter int EVENTS_PER_TRACK = 256,
   parameter int MAX_DUE          = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic [2:0] csr_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  ctl_type    ctl,
   output sts_type    sts
);

   localparam int DEPTH  = TRACKS * EVENTS_PER_TRACK;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int CW     = $clog2(TRACKS + 1);
   localparam int DW     = $clog2(MAX_DUE + 1);
   localparam int BUF_MAX = TRACKS * (2 + 2 * MAX_DUE) + 2;
   localparam int BW     = $clog2(BUF_MAX + 1);

   req_type          req_ff;
   logic [2:0]       tc_ff;
   event_type        ev_mem [DEPTH];
   event_type        ev_ff;
   logic [LEN_W-1:0] len_ff [TRACKS];
   logic [LEN_W-1:0] nxt_ff [TRACKS];
   logic [31:0]      end_ff [TRACKS];
   logic [CW-1:0]    act_ff;
   logic             run_ff;
   logic [31:0]      org_ff;
   logic [31:0]      ela_ff;
   logic [TW-1:0]    t_ff;
   logic [DW-1:0]    due_ff;
   logic             done_ff;
   entry_type        buf_mem [2**BW];
   logic [BW-1:0]    wp_ff, rp_ff;
   logic             ov_ff;
   rsp_type          out_ff;

   logic [31:0]      ld_tmp, rd_tmp;
   logic [AW-1:0]    ld_addr, rd_addr;
   logic             ld_ok;
   logic [1:0]       ev_ch;
   entry_type        wr_ent;
   logic [CW-1:0]    tc_clamp;
   logic             load_out;

   assign ld_ok   = (32'(req_ff.track) < TRACKS) && (32'(req_ff.event_index) < EVENTS_PER_TRACK);
   assign ld_tmp  = 32'(req_ff.track) * EVENTS_PER_TRACK + 32'(req_ff.event_index);
   assign ld_addr = ld_tmp[AW-1:0];
   assign rd_tmp  = 32'(t_ff) * EVENTS_PER_TRACK + 32'(nxt_ff[t_ff]);
   assign rd_addr = rd_tmp[AW-1:0];
   assign ev_ch   = (32'(ev_ff.ec) < CHANNELS) ? 2'(ev_ff.ec) : 2'(t_ff);
   assign tc_clamp = (32'(tc_ff) > TRACKS) ? CW'(TRACKS) : CW'(tc_ff);

   always_comb begin
      wr_ent.kind = ctl.wr_kind;
      case (ctl.wr_sel)
         SEL_OFF:  begin wr_ent.ch = 2'(t_ff); wr_ent.value = '0; end
         SEL_FREQ: begin wr_ent.ch = ev_ch; wr_ent.value = ev_ff.ph; end
         SEL_VOL:  begin wr_ent.ch = ev_ch; wr_ent.value = 32'(ev_ff.vo); end
         default:  begin wr_ent.ch = '0; wr_ent.value = '0; end
      endcase
   end

   assign sts.cmd       = req_ff.cmd;
   assign sts.run       = run_ff;
   assign sts.tc_nz     = (tc_ff != '0);
   assign sts.no_trk    = (act_ff == '0);
   assign sts.off_hit   = (end_ff[t_ff] != '0) && (ela_ff >= end_ff[t_ff]);
   assign sts.can_read  = (32'(due_ff) < MAX_DUE) && (nxt_ff[t_ff] < len_ff[t_ff])
                          && (32'(nxt_ff[t_ff]) < EVENTS_PER_TRACK);
   assign sts.ev_due    = (ev_ff.st <= ela_ff);
   assign sts.last_trk  = (32'(t_ff) + 32'd1 == 32'(act_ff));
   assign sts.trk_fin   = done_ff;
   assign sts.buf_empty = (rp_ff == wp_ff);

   always_ff @(posedge clock) begin
      if (ctl.dec) req_ff <= req_data;
      if (ctl.mem_wr && ld_ok) begin
         ev_mem[ld_addr] <= '{st: req_ff.start_time, du: req_ff.duration,
                              ph: req_ff.phase_increment, vo: req_ff.volume,
                              ec: req_ff.event_channel};
      end
      if (ctl.rd_issue) ev_ff <= ev_mem[rd_addr];
      if (ctl.wr_en) buf_mem[wp_ff] <= wr_ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff   <= '0;
         act_ff  <= '0;
         run_ff  <= 1'b0;
         org_ff  <= '0;
         ela_ff  <= '0;
         t_ff    <= '0;
         due_ff  <= '0;
         done_ff <= 1'b1;
         for (int i = 0; i < TRACKS; i++) begin
            len_ff[i] <= '0;
            nxt_ff[i] <= '0;
            end_ff[i] <= '0;
         end
      end else begin
         if (csr_we) tc_ff <= csr_data;
         if (ctl.mem_wr && ld_ok && req_ff.last_of_track) begin
            len_ff[TW'(req_ff.track)] <= LEN_W'(req_ff.event_index) + 1'b1;
         end
         if (ctl.play_init) begin
            for (int i = 0; i < TRACKS; i++) begin
               nxt_ff[i] <= '0;
               end_ff[i] <= '0;
            end
            act_ff <= tc_clamp;
            run_ff <= 1'b1;
            org_ff <= '0;
         end
         if (ctl.stop) run_ff <= 1'b0;
         if (ctl.origin) begin
            if (org_ff == '0) begin
               org_ff <= req_ff.now_ms;
               ela_ff <= '0;
            end else begin
               ela_ff <= req_ff.now_ms - org_ff;
            end
            t_ff    <= '0;
            due_ff  <= '0;
            done_ff <= 1'b1;
         end
         if (ctl.off_clr) end_ff[t_ff] <= '0;
         if (ctl.note_on) begin
            end_ff[t_ff] <= ev_ff.st + ev_ff.du;
            nxt_ff[t_ff] <= nxt_ff[t_ff] + 1'b1;
            due_ff       <= due_ff + 1'b1;
         end
         if (ctl.t_inc) begin
            if ((nxt_ff[t_ff] < len_ff[t_ff]) || (end_ff[t_ff] != '0)) done_ff <= 1'b0;
            t_ff   <= t_ff + 1'b1;
            due_ff <= '0;
         end
         if (ctl.fin && done_ff) run_ff <= 1'b0;
      end
   end

   // result buffer and output register
   assign load_out = ctl.drain && (rp_ff != wp_ff) && (!ov_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff.kind        <= buf_mem[rp_ff].kind;
         out_ff.osc_channel <= buf_mem[rp_ff].ch;
         out_ff.value       <= buf_mem[rp_ff].value;
         out_ff.playing     <= run_ff;
         out_ff.last        <= (rp_ff + 1'b1 == wp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) wp_ff <= wp_ff + 1'b1;
         if (load_out) begin
            rp_ff <= rp_ff + 1'b1;
            ov_ff <= 1'b1;
         end else if (!rsp_stall) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      32'(BW'(wp_ff - rp_ff)) <= BUF_MAX) else $error("result buffer overflow");
   a_fin_stop: assert property (@(posedge clock) disable iff (reset)
      ctl.fin && done_ff |=> !run_ff) else $error("finished playback still running");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");

endmodule

// ----- hw/rtl/note_event_sequencer.sv -----
`timescale 1ns / 1ps
// note_event_sequencer
// req channel (req_valid/req_stall/req_data): one beat per command: load event,
// play, stop or time tick. csr channel (csr_valid/csr_ready/csr_data) writes
// the track count register; csr_ready is always high, write only while idle.
// rsp channel (rsp_valid/rsp_stall/rsp_data): each command gives one or more
// beats, the final one a status beat with last set.
// a command is decoded, its results are collected in an internal buffer,
// then drained through the output register, so playing is final on every beat.
// load, play, stop: the command passes the decode and status states, then the
// drain loads the first result beat into the output register. tick while
// playing: origin, then per track a note-off check and one event memory read
// per due event (at most MAX_DUE), then finish and status before the drain;
// at most TRACKS * (2 + 2 * MAX_DUE) + 2 beats. the drain moves one beat per
// cycle while rsp_stall is low; the next command is taken once the buffer is empty.
// rsp_stall holds the output register; the buffer waits behind it.
// reset (synchronous, high) clears all tracks, playback and the track count;
// event memory contents are kept and are undefined until loaded.
module note_event_sequencer
   import nes_pkg::*;
#(
   parameter int TRACKS           = 4,
   parameter int CHANNELS         = 4,
   parameter int EVENTS_PER_TRACK = 256,
   parameter int MAX_DUE          = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_data
);

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   nes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   nes_datapath #(
      .TRACKS           (TRACKS),
      .CHANNELS         (CHANNELS),
      .EVENTS_PER_TRACK (EVENTS_PER_TRACK),
      .MAX_DUE          (MAX_DUE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule
